// ===== sv/urde_pkg.sv =====
`default_nettype none
package urde_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [7:0] SYNC_BYTE = 8'h05;
  localparam logic [7:0] WRITE_FLAG = 8'h80;
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [15:0] WECHO_RESET = 16'd3000;
  localparam logic [15:0] RECHO_RESET = 16'd5000;
  localparam logic [15:0] REPLY_RESET = 16'd20000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ = 2'd1,
    OP_RX = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_TX = 2'd0,
    KIND_DONE = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_CRC = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NODE = 4'd0,
    REG_WECHO = 4'd1,
    REG_RECHO = 4'd2,
    REG_REPLY = 4'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WECHO = 2'd1,
    PH_RECHO = 2'd2,
    PH_REPLY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    JOB_WRITE = 2'd0,
    JOB_READ = 2'd1,
    JOB_RELEASE = 2'd2,
    JOB_DONE = 2'd3
  } job_kind_t;

  typedef struct packed {
    logic [7:0] node_address;
    logic [TIMEOUT_W-1:0] write_echo_timeout_ticks;
    logic [TIMEOUT_W-1:0] read_echo_timeout_ticks;
    logic [TIMEOUT_W-1:0] reply_timeout_ticks;
  } cfg_t;

  // One queued request from the front: a datagram to send or a single result.
  typedef struct packed {
    job_kind_t kind;
    logic [7:0] node;
    logic [6:0] reg_addr;
    logic [31:0] value;
    status_t status;
  } job_t;

  typedef struct packed {
    logic full;
    logic has_data;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

  // CRC-8, polynomial 0x07, data bits fed least significant first.
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (c[7] ^ b[i]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/urde_front.sv =====
`default_nettype none
module urde_front #(
  parameter int TIMER_BITS = urde_pkg::TIMER_BITS_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_fire,
  input  wire logic [1:0]      op,
  input  wire logic [6:0]      reg_addr,
  input  wire logic [31:0]     write_value,
  input  wire logic [7:0]      rx_byte,
  input  wire urde_pkg::cfg_t  cfg,
  output logic                 job_push,
  output urde_pkg::job_t       job
);
  import urde_pkg::*;

  localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  phase_t phase, phase_next;
  logic [3:0] byte_count, byte_count_next;
  logic [TIMER_BITS-1:0] wait_timer, wait_timer_next;
  logic [7:0] reply_crc, reply_crc_next;
  logic [31:0] reply_word, reply_word_next;

  logic [TIMEOUT_W-1:0] limit;
  logic [TIMER_BITS-1:0] timer_inc;
  logic expired;
  logic [3:0] cnt_inc;
  logic [3:0] need;
  logic advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_count <= 4'd0;
      wait_timer <= '0;
      reply_crc <= 8'd0;
      reply_word <= 32'd0;
    end else if (in_fire) begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      wait_timer <= wait_timer_next;
      reply_crc <= reply_crc_next;
      reply_word <= reply_word_next;
    end
  end

  always_comb begin
    case (phase)
      PH_WECHO: limit = cfg.write_echo_timeout_ticks;
      PH_RECHO: limit = cfg.read_echo_timeout_ticks;
      default:  limit = cfg.reply_timeout_ticks;
    endcase
    timer_inc = (wait_timer != TMAX) ? wait_timer + 1'b1 : wait_timer;
    expired = (CMP_W'(timer_inc) >= CMP_W'(limit)) || (timer_inc == TMAX);
    cnt_inc = byte_count + 4'd1;
    need = (phase == PH_WECHO) ? 4'd8 : 4'd4;
    advance = (op_t'(op) == OP_RX) || expired;
  end

  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    wait_timer_next = wait_timer;
    reply_crc_next = reply_crc;
    reply_word_next = reply_word;
    job_push = 1'b0;
    job.kind = JOB_DONE;
    job.node = cfg.node_address;
    job.reg_addr = reg_addr;
    job.value = write_value;
    job.status = ST_OK;

    case (phase)
      PH_IDLE: begin
        if (op_t'(op) == OP_WRITE || op_t'(op) == OP_READ) begin
          job_push = in_fire;
          job.kind = (op_t'(op) == OP_WRITE) ? JOB_WRITE : JOB_READ;
          phase_next = (op_t'(op) == OP_WRITE) ? PH_WECHO : PH_RECHO;
          byte_count_next = 4'd0;
          wait_timer_next = '0;
        end
      end
      PH_WECHO, PH_RECHO: begin
        if (op_t'(op) == OP_RX || op_t'(op) == OP_TICK) begin
          if (advance) begin
            wait_timer_next = '0;
            byte_count_next = cnt_inc;
            if (cnt_inc >= need) begin
              byte_count_next = 4'd0;
              if (phase == PH_WECHO) begin
                phase_next = PH_IDLE;
              end else begin
                phase_next = PH_REPLY;
                reply_crc_next = 8'd0;
                reply_word_next = 32'd0;
                job_push = in_fire;
                job.kind = JOB_RELEASE;
              end
            end
          end else begin
            wait_timer_next = timer_inc;
          end
        end
      end
      PH_REPLY: begin
        if (op_t'(op) == OP_TICK) begin
          if (expired) begin
            job_push = in_fire;
            job.kind = JOB_DONE;
            job.value = ALL_ONES;
            job.status = ST_TIMEOUT;
            phase_next = PH_IDLE;
            byte_count_next = 4'd0;
            wait_timer_next = '0;
          end else begin
            wait_timer_next = timer_inc;
          end
        end else if (op_t'(op) == OP_RX) begin
          wait_timer_next = '0;
          if (byte_count < 4'd7) begin
            reply_crc_next = crc_byte(reply_crc, rx_byte);
            if (byte_count >= 4'd3) begin
              reply_word_next = {reply_word[23:0], rx_byte};
            end
            byte_count_next = cnt_inc;
          end else begin
            job_push = in_fire;
            job.kind = JOB_DONE;
            if (rx_byte == reply_crc) begin
              job.value = reply_word;
              job.status = ST_OK;
            end else begin
              job.value = ALL_ONES;
              job.status = ST_CRC;
            end
            phase_next = PH_IDLE;
            byte_count_next = 4'd0;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        byte_count_next = 4'd0;
        wait_timer_next = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/urde_queue.sv =====
`default_nettype none
module urde_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_en,
  input  wire urde_pkg::job_t   push_job,
  input  wire logic             pop_en,
  output urde_pkg::job_t        head,
  output urde_pkg::queue_stat_t stat
);
  import urde_pkg::*;

  job_t entries [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic do_push, do_pop;

  assign do_push = push_en && (count != QCNT_W'(QDEPTH));
  assign do_pop = pop_en && (count != '0);
  assign head = entries[rptr];
  assign stat.full = (count == QCNT_W'(QDEPTH));
  assign stat.has_data = (count != '0);
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== sv/urde_back.sv =====
`default_nettype none
module urde_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire urde_pkg::job_t head,
  output logic                head_pop,
  input  wire logic           pop,
  output logic                out_valid,
  output logic [1:0]          kind,
  output logic [7:0]          tx_byte,
  output logic                last_byte,
  output logic [31:0]         read_value,
  output logic [1:0]          read_status
);
  import urde_pkg::*;

  logic [2:0] idx;
  logic [7:0] crc;
  logic go;
  logic is_dgram;
  logic is_last;
  logic [7:0] data_byte;

  assign go = head_valid && (!out_valid || pop);
  assign is_dgram = (head.kind == JOB_WRITE) || (head.kind == JOB_READ);
  assign is_last = (head.kind == JOB_WRITE) ? (idx == 3'd7) : (idx == 3'd3);

  always_comb begin
    case (idx)
      3'd0: data_byte = SYNC_BYTE;
      3'd1: data_byte = head.node;
      3'd2: data_byte = (head.kind == JOB_WRITE) ? ({1'b0, head.reg_addr} | WRITE_FLAG)
                                                 : {1'b0, head.reg_addr};
      3'd3: data_byte = head.value[31:24];
      3'd4: data_byte = head.value[23:16];
      3'd5: data_byte = head.value[15:8];
      3'd6: data_byte = head.value[7:0];
      default: data_byte = 8'd0;
    endcase
    // A datagram job stays at the head until its CRC byte goes out.
    head_pop = go && (!is_dgram || is_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= 3'd0;
      crc <= 8'd0;
    end else if (go) begin
      out_valid <= 1'b1;
      if (is_dgram && !is_last) begin
        idx <= idx + 3'd1;
        crc <= crc_byte(crc, data_byte);
      end else begin
        idx <= 3'd0;
        crc <= 8'd0;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (is_dgram) begin
        kind <= KIND_TX;
        tx_byte <= is_last ? crc : data_byte;
        last_byte <= is_last;
        read_value <= 32'd0;
        read_status <= ST_OK;
      end else begin
        kind <= (head.kind == JOB_RELEASE) ? KIND_RELEASE : KIND_DONE;
        tx_byte <= 8'd0;
        last_byte <= 1'b0;
        read_value <= (head.kind == JOB_RELEASE) ? 32'd0 : head.value;
        read_status <= (head.kind == JOB_RELEASE) ? ST_OK : head.status;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/uart_register_datagram_engine_unit.sv =====
// Channel  | Handshake          | Ports
// ---------+--------------------+--------------------------------------------------
// input    | push / full        | op, reg_addr, write_value, rx_byte
// result   | empty / pop        | kind, tx_byte, last_byte, read_value, read_status
// config   | cfg_we             | cfg_index, cfg_data
//
// The front takes one request per cycle while the two-entry job queue has room.
// The back sends one result per cycle while results are popped: a write datagram occupies it
// for 8 bytes, a read datagram for 4, a release or read completion for 1 result.
// Reset clears the link state, the queue and the output register, and loads
// the register defaults. A held-off pop stalls the back only; the front keeps
// accepting requests until the job queue fills.
`default_nettype none
module uart_register_datagram_engine_unit #(
  parameter int TIMER_BITS = urde_pkg::TIMER_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [1:0]                        op,
  input  wire logic [6:0]                        reg_addr,
  input  wire logic [31:0]                       write_value,
  input  wire logic [7:0]                        rx_byte,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [1:0]                             kind,
  output logic [7:0]                             tx_byte,
  output logic                                   last_byte,
  output logic [31:0]                            read_value,
  output logic [1:0]                             read_status,
  input  wire logic                              cfg_we,
  input  wire logic [urde_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [urde_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import urde_pkg::*;

  cfg_t cfg;
  logic in_fire;
  logic job_push;
  job_t job;
  job_t head;
  queue_stat_t q_stat;
  logic head_pop;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_address <= 8'd0;
      cfg.write_echo_timeout_ticks <= WECHO_RESET;
      cfg.read_echo_timeout_ticks <= RECHO_RESET;
      cfg.reply_timeout_ticks <= REPLY_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_NODE:  cfg.node_address <= cfg_data[7:0];
        REG_WECHO: cfg.write_echo_timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        REG_RECHO: cfg.read_echo_timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        REG_REPLY: cfg.reply_timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign full = q_stat.full;
  assign in_fire = push && !q_stat.full;
  assign empty = !out_valid;

  urde_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_fire(in_fire),
    .op(op),
    .reg_addr(reg_addr),
    .write_value(write_value),
    .rx_byte(rx_byte),
    .cfg(cfg),
    .job_push(job_push),
    .job(job)
  );

  urde_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push_en(job_push),
    .push_job(job),
    .pop_en(head_pop),
    .head(head),
    .stat(q_stat)
  );

  urde_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(q_stat.has_data),
    .head(head),
    .head_pop(head_pop),
    .pop(pop),
    .out_valid(out_valid),
    .kind(kind),
    .tx_byte(tx_byte),
    .last_byte(last_byte),
    .read_value(read_value),
    .read_status(read_status)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("job queue count above its depth");

  a_last_is_tx: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_byte) |-> (kind == KIND_TX))
    else $error("last_byte set on a result that is not a transmit byte");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_TX) |-> (tx_byte == 8'd0 && !last_byte))
    else $error("non-transmit result carries transmit fields");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (job_push && !in_fire) |-> 1'b0)
    else $error("job request raised without an accepted input");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import urde_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 32;
  localparam int ITEMS_PER_SETTING = 12;
  localparam logic [15:0] TIMER_MAX = '1;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx;
    logic        last;
    logic [31:0] value;
    status_t     status;
  } link_result_t;

  typedef struct {
    op_t          op;
    logic [6:0]   reg_addr;
    logic [31:0]  value;
    logic [7:0]   rx;
    bit           has_want;
    link_result_t want;
  } request_row_t;

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  logic [1:0]             op;
  logic [6:0]             reg_addr;
  logic [31:0]            write_value;
  logic [7:0]             rx_byte;
  logic                   empty;
  logic                   pop;
  logic [1:0]             kind;
  logic [7:0]             tx_byte;
  logic                   last_byte;
  logic [31:0]            read_value;
  logic [1:0]             read_status;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Link state and register copies of the predictor.
  phase_t      link_phase;
  logic [3:0]  link_count;
  logic [15:0] link_timer;
  logic [7:0]  link_crc;
  logic [31:0] link_word;
  logic [7:0]  node_reg;
  logic [15:0] wecho_limit;
  logic [15:0] recho_limit;
  logic [15:0] reply_limit;

  link_result_t step_results[$];
  link_result_t pending_results[$];
  request_row_t directed_rows[$];

  bit took_effect;
  bit calm = 1'b0;
  int items_sent = 0;
  int effective_items = 0;
  int results_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int settings_used = 0;

  uart_register_datagram_engine_unit u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .op(op),
    .reg_addr(reg_addr),
    .write_value(write_value),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .tx_byte(tx_byte),
    .last_byte(last_byte),
    .read_value(read_value),
    .read_status(read_status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("uart_register_datagram_engine_unit verification failed");
      $finish;
    end
  end

  // CRC-8, polynomial 0x07: data bits enter least significant first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    repeat (8) begin
      if (c[7] ^ d[0]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
      d = d >> 1;
    end
    return c;
  endfunction

  function automatic link_result_t make_result(input kind_t k, input logic [7:0] tx,
                                               input logic last, input logic [31:0] value,
                                               input status_t st);
    link_result_t r;
    r.kind = k;
    r.tx = tx;
    r.last = last;
    r.value = value;
    r.status = st;
    return r;
  endfunction

  // One tick of the wait timer, which saturates at its maximum.
  function automatic bit timer_tick_expired(input logic [15:0] limit);
    if (link_timer != TIMER_MAX) begin
      link_timer = link_timer + 16'd1;
    end
    return (link_timer >= limit) || (link_timer == TIMER_MAX);
  endfunction

  task automatic predict_request(input op_t op_i, input logic [6:0] reg_i,
                                 input logic [31:0] val_i, input logic [7:0] rx_i);
    logic [7:0]  frame [8];
    logic [7:0]  crc;
    logic [15:0] limit;
    logic [3:0]  need;
    int          len;
    bit          moved;
    step_results.delete();
    took_effect = 1'b1;
    case (link_phase)
      PH_IDLE: begin
        if (op_i == OP_WRITE || op_i == OP_READ) begin
          frame[0] = SYNC_BYTE;
          frame[1] = node_reg;
          if (op_i == OP_WRITE) begin
            frame[2] = {1'b0, reg_i} | WRITE_FLAG;
            {frame[3], frame[4], frame[5], frame[6]} = val_i;
            len = 8;
            link_phase = PH_WECHO;
          end else begin
            frame[2] = {1'b0, reg_i};
            len = 4;
            link_phase = PH_RECHO;
          end
          crc = 8'h00;
          for (int i = 0; i < len - 1; i++) begin
            crc = crc8_update(crc, frame[i]);
          end
          frame[len - 1] = crc;
          for (int i = 0; i < len; i++) begin
            step_results.push_back(make_result(KIND_TX, frame[i], i == len - 1, '0, ST_OK));
          end
          link_count = '0;
          link_timer = '0;
        end else begin
          took_effect = 1'b0;
        end
      end
      PH_WECHO, PH_RECHO: begin
        if (op_i == OP_RX || op_i == OP_TICK) begin
          limit = (link_phase == PH_WECHO) ? wecho_limit : recho_limit;
          need = (link_phase == PH_WECHO) ? 4'd8 : 4'd4;
          if (op_i == OP_RX) begin
            moved = 1'b1;
          end else begin
            moved = timer_tick_expired(limit);
          end
          // Echo contents are dropped; a byte or an expired wait counts the same.
          if (moved) begin
            link_count = link_count + 4'd1;
            link_timer = '0;
            if (link_count >= need) begin
              link_count = '0;
              if (link_phase == PH_WECHO) begin
                link_phase = PH_IDLE;
              end else begin
                link_phase = PH_REPLY;
                link_crc = '0;
                link_word = '0;
                step_results.push_back(make_result(KIND_RELEASE, '0, 1'b0, '0, ST_OK));
              end
            end
          end
        end else begin
          took_effect = 1'b0;
        end
      end
      default: begin
        if (op_i == OP_TICK) begin
          if (timer_tick_expired(reply_limit)) begin
            step_results.push_back(make_result(KIND_DONE, '0, 1'b0, ALL_ONES, ST_TIMEOUT));
            link_phase = PH_IDLE;
            link_count = '0;
            link_timer = '0;
          end
        end else if (op_i == OP_RX) begin
          link_timer = '0;
          if (link_count < 4'd7) begin
            // The first three reply bytes only feed the CRC.
            link_crc = crc8_update(link_crc, rx_i);
            if (link_count >= 4'd3) begin
              link_word = {link_word[23:0], rx_i};
            end
            link_count = link_count + 4'd1;
          end else begin
            if (rx_i == link_crc) begin
              step_results.push_back(make_result(KIND_DONE, '0, 1'b0, link_word, ST_OK));
            end else begin
              step_results.push_back(make_result(KIND_DONE, '0, 1'b0, ALL_ONES, ST_CRC));
            end
            link_phase = PH_IDLE;
            link_count = '0;
          end
        end else begin
          took_effect = 1'b0;
        end
      end
    endcase
  endtask

  task automatic send_request(input op_t op_i, input logic [6:0] reg_i,
                              input logic [31:0] val_i, input logic [7:0] rx_i,
                              input bit has_want = 1'b0, input link_result_t want = '0);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    op <= op_i;
    reg_addr <= reg_i;
    write_value <= val_i;
    rx_byte <= rx_i;
    do @(posedge clk); while (full !== 1'b0);
    predict_request(op_i, reg_i, val_i, rx_i);
    // A typed-in expectation stands in for the first predicted result of the request.
    if (has_want) begin
      if (step_results.size() == 0) begin
        step_results.push_back(want);
      end else begin
        step_results[0] = want;
      end
    end
    foreach (step_results[i]) begin
      pending_results.push_back(step_results[i]);
    end
    items_sent++;
    if (took_effect) begin
      effective_items++;
    end
  endtask

  task automatic send_op(input op_t op_i);
    send_request(op_i, 7'($urandom), $urandom, 8'($urandom));
  endtask

  task automatic spare_ticks(input logic [15:0] limit);
    int spare;
    spare = (limit == 16'd0) ? 0 : ((limit > 16'd4) ? 3 : int'(limit) - 1);
    repeat ($urandom_range(0, spare)) send_op(OP_TICK);
  endtask

  task automatic expire_wait(input logic [15:0] limit);
    repeat ((limit == 16'd0) ? 1 : int'(limit)) send_op(OP_TICK);
  endtask

  task automatic drive_echo(input logic [15:0] limit);
    if ($urandom_range(0, 5) == 0) begin
      send_op($urandom_range(0, 1) ? OP_WRITE : OP_READ);
    end
    if (limit <= 16'd6 && $urandom_range(0, 1) == 1) begin
      expire_wait(limit);
    end else begin
      spare_ticks(limit);
      send_op(OP_RX);
    end
  endtask

  task automatic run_write;
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    send_request(OP_WRITE, 7'($urandom), v, 8'($urandom));
    repeat (8) drive_echo(wecho_limit);
  endtask

  task automatic run_read;
    int         cut;
    logic [7:0] b;
    send_op(OP_READ);
    repeat (4) drive_echo(recho_limit);
    cut = 8;
    if (reply_limit <= 16'd6 && $urandom_range(0, 3) == 0) begin
      cut = $urandom_range(0, 7);
    end
    for (int i = 0; i < 7 && i < cut; i++) begin
      spare_ticks(reply_limit);
      case ($urandom_range(0, 3))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_request(OP_RX, 7'($urandom), $urandom, b);
    end
    if (cut < 8) begin
      expire_wait(reply_limit);
    end else begin
      spare_ticks(reply_limit);
      b = link_crc;
      if ($urandom_range(0, 4) == 0) begin
        b = b ^ 8'($urandom_range(1, 255));
      end
      send_request(OP_RX, 7'($urandom), $urandom, b);
    end
  endtask

  // Waits until every expected result is out and the block has had time to go quiet.
  task automatic settle_link;
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] node_data, input logic [15:0] w,
                               input logic [15:0] r, input logic [15:0] p);
    cfg_we <= 1'b1;
    cfg_index <= REG_NODE;
    cfg_data <= node_data;
    @(posedge clk);
    node_reg = node_data[7:0];
    cfg_index <= REG_WECHO;
    cfg_data <= w;
    @(posedge clk);
    wecho_limit = w;
    cfg_index <= REG_RECHO;
    cfg_data <= r;
    @(posedge clk);
    recho_limit = r;
    cfg_index <= REG_REPLY;
    cfg_data <= p;
    @(posedge clk);
    reply_limit = p;
    // An index past the last register must leave every setting alone.
    cfg_index <= CFG_INDEX_W'($urandom_range(4, 15));
    cfg_data <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_setting(input logic [15:0] node_data, input logic [15:0] w,
                             input logic [15:0] r, input logic [15:0] p);
    int start;
    int pick;
    settle_link();
    load_settings(node_data, w, r, p);
    start = effective_items;
    while (effective_items - start < ITEMS_PER_SETTING) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 3)) send_op(op_t'($urandom_range(0, 3)));
      end else if (pick < 5) begin
        run_write();
      end else begin
        run_read();
      end
    end
    while (link_phase != PH_IDLE) send_op(OP_RX);
  endtask

  task automatic add_row(input op_t op_i, input logic [6:0] reg_i, input logic [31:0] val_i,
                         input logic [7:0] rx_i, input bit has_want = 1'b0,
                         input link_result_t want = '0);
    request_row_t row;
    row.op = op_i;
    row.reg_addr = reg_i;
    row.value = val_i;
    row.rx = rx_i;
    row.has_want = has_want;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  initial begin : result_sink
    int           stall_left;
    link_result_t want;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request behind it: kind %0d tx %0h value %0h status %0d",
                   $time, kind, tx_byte, read_value, read_status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("tx_byte", want.tx, tx_byte);
          check_field("last_byte", want.last, last_byte);
          check_field("read_value", want.value, read_value);
          check_field("read_status", want.status, read_status);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int         split;
    logic [7:0] reply_crc;
    rst <= 1'b1;
    push <= 1'b0;
    op <= OP_WRITE;
    reg_addr <= '0;
    write_value <= '0;
    rx_byte <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_NODE;
    cfg_data <= '0;
    link_phase = PH_IDLE;
    link_count = '0;
    link_timer = '0;
    link_crc = '0;
    link_word = '0;
    node_reg = 8'h00;
    wecho_limit = WECHO_RESET;
    recho_limit = RECHO_RESET;
    reply_limit = REPLY_RESET;

    // Register defaults: idle traffic, a read with a busy write in its echo wait,
    // and a reply of all ones whose CRC byte is off by one bit.
    add_row(OP_RX, 7'h00, 32'h0, 8'hA5);
    add_row(OP_TICK, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    add_row(OP_READ, 7'h7F, 32'h0, 8'h00, 1'b1,
            make_result(KIND_TX, SYNC_BYTE, 1'b0, '0, ST_OK));
    add_row(OP_WRITE, 7'h00, 32'hFFFF_FFFF, 8'h00);
    add_row(OP_RX, 7'h00, 32'h0, 8'h00);
    add_row(OP_RX, 7'h00, 32'h0, 8'hFF);
    add_row(OP_RX, 7'h00, 32'h0, 8'h55);
    add_row(OP_RX, 7'h00, 32'h0, 8'hAA, 1'b1,
            make_result(KIND_RELEASE, '0, 1'b0, '0, ST_OK));
    reply_crc = 8'h00;
    repeat (7) begin
      add_row(OP_RX, 7'h00, 32'h0, 8'hFF);
      reply_crc = crc8_update(reply_crc, 8'hFF);
    end
    add_row(OP_RX, 7'h00, 32'h0, reply_crc ^ 8'h01, 1'b1,
            make_result(KIND_DONE, '0, 1'b0, ALL_ONES, ST_CRC));
    split = directed_rows.size();
    // Zero write echo timeout, one-tick read echo and reply timeouts: every wait
    // expires on ticks, and the read ends in a reply timeout.
    add_row(OP_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'h00, 1'b1,
            make_result(KIND_TX, SYNC_BYTE, 1'b0, '0, ST_OK));
    repeat (8) add_row(OP_TICK, 7'h00, 32'h0, 8'h00);
    add_row(OP_READ, 7'h00, 32'h0, 8'h00, 1'b1,
            make_result(KIND_TX, SYNC_BYTE, 1'b0, '0, ST_OK));
    repeat (3) add_row(OP_TICK, 7'h00, 32'h0, 8'h00);
    add_row(OP_TICK, 7'h00, 32'h0, 8'h00, 1'b1,
            make_result(KIND_RELEASE, '0, 1'b0, '0, ST_OK));
    add_row(OP_TICK, 7'h00, 32'h0, 8'h00, 1'b1,
            make_result(KIND_DONE, '0, 1'b0, ALL_ONES, ST_TIMEOUT));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < split; i++) begin
      send_request(directed_rows[i].op, directed_rows[i].reg_addr, directed_rows[i].value,
                   directed_rows[i].rx, directed_rows[i].has_want, directed_rows[i].want);
    end
    settle_link();
    load_settings(16'hC3FF, 16'd0, 16'd1, 16'd1);
    for (int i = split; i < directed_rows.size(); i++) begin
      send_request(directed_rows[i].op, directed_rows[i].reg_addr, directed_rows[i].value,
                   directed_rows[i].rx, directed_rows[i].has_want, directed_rows[i].want);
    end

    run_setting(16'h0000, 16'd1, 16'd1, 16'd1);
    run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_setting(16'($urandom), 16'd0, 16'd0, 16'd0);
    run_setting(16'($urandom), 16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                16'($urandom_range(0, 6)));
    calm = 1'b1;
    run_setting(16'($urandom), 16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                16'($urandom_range(0, 6)));
    settle_link();

    $display("Sent %0d requests (%0d not ignored) under %0d register settings; checked %0d results.",
             items_sent, effective_items, settings_used, results_seen);
    $display("Traffic mixed write and read datagrams, echo and reply timeouts, CRC errors and noise.");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("uart_register_datagram_engine_unit verification clean");
    end else begin
      $display("uart_register_datagram_engine_unit verification failed");
    end
    $finish;
  end

endmodule
